>>> sv/round_robin_thread_ring_unit_assert.svh
// ----------------------------------------------------------------------------
// round robin thread ring assertion macros
// shared property forms for the ring controller checks
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_RING_UNIT_ASSERT_SVH
`define ROUND_ROBIN_THREAD_RING_UNIT_ASSERT_SVH

// same-cycle implication, off while in reset
`define RRTR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrtr: implication check failed");

// next-cycle implication, off while in reset
`define RRTR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrtr: next-cycle check failed");

`endif

>>> sv/rrtr_pkg.sv
// ----------------------------------------------------------------------------
// rrtr_pkg
// shared constants, codes and types of the round robin thread ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrtr_pkg;

  // ring capacity and identifier width
  localparam int MAX_THREADS = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;

  // operation codes of an input item
  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_YIELD = 2'd1,
    OP_TERM  = 2'd2
  } op_e;

  // status codes of a result item
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FEW     = 3'd2,
    ST_MISSING = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_e;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic               step;     // every cell takes from its neighbour
    logic               drop;     // head leaves the ring, no wrap this step
    logic               load;     // write load_id at position count
    logic [ID_BITS-1:0] load_id;
    logic [CNT_W-1:0]   count;    // occupancy before this cycle
  } ctl_t;

endpackage

>>> sv/rrtr_cell.sv
// ----------------------------------------------------------------------------
// rrtr_cell
// one position of the ring; position zero is the running thread
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrtr_cell (
  input  logic                        clk_i,
  input  logic [rrtr_pkg::IDX_W-1:0]  idx_i,
  input  rrtr_pkg::ctl_t              ctl_i,
  input  logic [rrtr_pkg::ID_BITS-1:0] nbr_i,
  input  logic [rrtr_pkg::ID_BITS-1:0] head_i,
  output logic [rrtr_pkg::ID_BITS-1:0] id_o
);
  import rrtr_pkg::*;

  logic [ID_BITS-1:0] id_q, id_d;
  logic [CNT_W-1:0]   pos;
  logic               at_tail;

  // position compares against the occupancy
  assign pos     = CNT_W'(idx_i);
  assign at_tail = (pos + CNT_W'(1)) == ctl_i.count;

  // load at the first free slot past the tail, otherwise shift towards the head with wrap
  always_comb begin
    id_d = id_q;
    if (ctl_i.load && (pos == ctl_i.count)) begin
      id_d = ctl_i.load_id;
    end else if (ctl_i.step) begin
      if (!ctl_i.drop && at_tail) begin
        id_d = head_i;
      end else begin
        id_d = nbr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o = id_q;

endmodule

>>> sv/rrtr_ctrl.sv
// ----------------------------------------------------------------------------
// rrtr_ctrl
// sequencer for add, yield and terminate, plus the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "round_robin_thread_ring_unit_assert.svh"

module rrtr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rrtr_pkg::OP_W-1:0]     op_i,
  input  logic [rrtr_pkg::ID_BITS-1:0]  thread_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rrtr_pkg::ID_BITS-1:0]  run_thread_o,
  output logic                          run_valid_o,
  output logic [rrtr_pkg::STATUS_W-1:0] status_o,
  output logic [rrtr_pkg::CNT_W-1:0]    thread_total_o,
  input  logic [rrtr_pkg::ID_BITS-1:0]  head_i,
  output rrtr_pkg::ctl_t                ctl_o
);
  import rrtr_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   walk_q, walk_d;
  logic               found_q, found_d;
  logic [ID_BITS-1:0] id_q, id_d;
  status_e            st_q, st_d;
  logic               out_valid_q, out_valid_d;
  logic [ID_BITS-1:0] run_thread_q, run_thread_d;
  logic               run_valid_q, run_valid_d;
  status_e            status_q, status_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic               hit;

  assign hit = !found_q && (head_i == id_q);

  // next state, cell control and result load
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    walk_d       = walk_q;
    found_d      = found_q;
    id_d         = id_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q;
    run_thread_d = run_thread_q;
    run_valid_d  = run_valid_q;
    status_d     = status_q;
    total_d      = total_q;
    in_ready_o   = 1'b0;
    ctl_o.step    = 1'b0;
    ctl_o.drop    = 1'b0;
    ctl_o.load    = 1'b0;
    ctl_o.load_id = thread_id_i;
    ctl_o.count   = count_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          id_d    = thread_id_i;
          found_d = 1'b0;
          st_d    = ST_OK;
          state_d = S_DONE;
          case (op_i)
            OP_ADD: begin
              if (count_q >= CNT_W'(MAX_THREADS)) begin
                st_d = ST_FULL;
              end else begin
                ctl_o.load = 1'b1;
                count_d    = count_q + CNT_W'(1);
              end
            end
            OP_YIELD: begin
              if (count_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                ctl_o.step = 1'b1;
              end
            end
            OP_TERM: begin
              if (count_q < CNT_W'(2)) begin
                st_d = ST_FEW;
              end else begin
                // target running: hand over to the next thread first
                ctl_o.step = (head_i == thread_id_i);
                walk_d     = count_q;
                state_d    = S_WALK;
              end
            end
            default: begin
              st_d = ST_OK;
            end
          endcase
        end
      end

      // one full revolution; the first match is dropped at the head
      S_WALK: begin
        ctl_o.step = 1'b1;
        if (hit) begin
          ctl_o.drop = 1'b1;
          found_d    = 1'b1;
          count_d    = count_q - CNT_W'(1);
        end
        walk_d = walk_q - CNT_W'(1);
        if (walk_q == CNT_W'(1)) begin
          st_d    = (found_q || hit) ? ST_OK : ST_MISSING;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          run_valid_d  = (count_q != '0);
          run_thread_d = (count_q != '0) ? head_i : '0;
          status_d     = st_q;
          total_d      = count_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    st_q         <= st_d;
    run_thread_q <= run_thread_d;
    run_valid_q  <= run_valid_d;
    status_q     <= status_d;
    total_q      <= total_d;
  end

  assign out_valid_o    = out_valid_q;
  assign run_thread_o   = run_thread_q;
  assign run_valid_o    = run_valid_q;
  assign status_o       = status_q;
  assign thread_total_o = total_q;

  // checks
  `RRTR_ASSERT_IMP(a_count_cap, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_THREADS))
  `RRTR_ASSERT_IMP(a_walk_live, clk_i, rst_ni, state_q == S_WALK,
                   (walk_q != '0) && (count_q != '0))
  `RRTR_ASSERT_IMP(a_full_total, clk_i, rst_ni, out_valid_q && (status_q == ST_FULL),
                   total_q == CNT_W'(MAX_THREADS))
  `RRTR_ASSERT_IMP(a_run_valid, clk_i, rst_ni, out_valid_q,
                   run_valid_q == (total_q != '0))
  `RRTR_ASSERT_NXT(a_drop_count, clk_i, rst_ni, ctl_o.drop && (state_q == S_WALK),
                   count_q != CNT_W'(MAX_THREADS))

endmodule

>>> sv/round_robin_thread_ring_unit.sv
// ----------------------------------------------------------------------------
// round_robin_thread_ring_unit
// round robin ready queue kept as a rotating chain of identifier cells
// ----------------------------------------------------------------------------
// channel  | direction | handshake                | payload
// in       | input     | in_valid_i / in_ready_o  | op_i, thread_id_i
// out      | output    | out_valid_o / out_ready_i| run_thread_o, run_valid_o,
//          |           |                          | status_o, thread_total_o
//
// add, yield and rejected items: the done state loads the output register,
// then idle takes the next item. terminate with n threads: the chain makes
// one full revolution, one cell step per cycle, before the done state.
// one item at a time; a result waits in the output register while the next
// item is taken, and a stalled result holds the sequencer in its last state.
// reset empties the ring at once; cell contents need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_thread_ring_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rrtr_pkg::OP_W-1:0]     op_i,
  input  logic [rrtr_pkg::ID_BITS-1:0]  thread_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rrtr_pkg::ID_BITS-1:0]  run_thread_o,
  output logic                          run_valid_o,
  output logic [rrtr_pkg::STATUS_W-1:0] status_o,
  output logic [rrtr_pkg::CNT_W-1:0]    thread_total_o
);
  import rrtr_pkg::*;

  ctl_t               ctl;
  logic [ID_BITS-1:0] cell_id [MAX_THREADS];

  // sequencer and result register
  rrtr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .thread_id_i    (thread_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .run_thread_o   (run_thread_o),
    .run_valid_o    (run_valid_o),
    .status_o       (status_o),
    .thread_total_o (thread_total_o),
    .head_i         (cell_id[0]),
    .ctl_o          (ctl)
  );

  // chain of cells, each taking from the next one up
  for (genvar g = 0; g < MAX_THREADS; g++) begin : g_cell
    rrtr_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(g)),
      .ctl_i  (ctl),
      .nbr_i  (cell_id[(g + 1) % MAX_THREADS]),
      .head_i (cell_id[0]),
      .id_o   (cell_id[g])
    );
  end

endmodule
